>>> design/cxmp_pkg.sv
// Shared types and constants for the CoreXY move planner.
package cxmp_pkg;

  localparam int OP_W        = 3;
  localparam int COORD_W     = 24;
  localparam int DUR_W       = 32;
  localparam int SPM_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 2 * COORD_W + DUR_W;
  localparam int ROUND_SHIFT = 26;

  localparam logic [SPM_W-1:0] SPM_RESET = 32'd6675443;

  typedef enum logic [OP_W-1:0] {
    OP_MOVE_REL       = 3'd0,
    OP_MOVE_ABS       = 3'd1,
    OP_SET_POS        = 3'd2,
    OP_CAPTURE_LIMIT  = 3'd3,
    OP_CAPTURE_ORIGIN = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLAMP_ENABLE = 1'b0,
    CFG_STEPS_PER_MM = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic [DUR_W-1:0] dur;
  } stg_t;

endpackage

>>> design/cxmp_pos.sv
// Position stage: pen position, origin and limit registers, clamping.
module cxmp_pos #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 clamp_en,
  input  logic                                 in_valid,
  input  cxmp_pkg::op_t                        op,
  input  logic signed [cxmp_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [cxmp_pkg::COORD_W-1:0]  coord_y,
  input  logic        [cxmp_pkg::DUR_W-1:0]    dur,
  input  logic                                 dn_rdy,
  output logic                                 in_rdy,
  output cxmp_pkg::stg_t                       item,
  output logic signed [POSITION_WIDTH-1:0]     pos_x,
  output logic signed [POSITION_WIDTH-1:0]     pos_y
);
  import cxmp_pkg::*;

  localparam int PW = POSITION_WIDTH;
  localparam int XW = (PW > COORD_W ? PW : COORD_W) + 1;
  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [XW-1:0] v);
    logic [XW-PW:0] hi;
    hi = v[XW-1:PW-1];
    if ((&hi) || !(|hi)) return v[PW-1:0];
    else if (v[XW-1]) return POS_MIN;
    else return POS_MAX;
  endfunction

  function automatic logic signed [PW-1:0] clamp_axis(input logic signed [PW-1:0] v,
                                                      input logic signed [PW-1:0] lim);
    if (v[PW-1]) return '0;
    else if (v > lim) return lim;
    else return v;
  endfunction

  logic signed [PW-1:0] cur_x_r, cur_y_r, org_x_r, org_y_r, lim_x_r, lim_y_r;
  logic signed [PW-1:0] cur_x_nxt, cur_y_nxt, org_x_nxt, org_y_nxt, lim_x_nxt, lim_y_nxt;
  stg_t                 item_r, item_nxt;
  logic                 acc;
  logic signed [PW-1:0] base_x, base_y, tgt_x, tgt_y;
  logic signed [XW-1:0] sum_x, sum_y;

  assign in_rdy = !item_r.valid || dn_rdy;
  assign acc    = in_valid && in_rdy;
  assign item   = item_r;
  assign pos_x  = cur_x_r;
  assign pos_y  = cur_y_r;

  always_comb begin
    base_x = (op == OP_MOVE_ABS) ? org_x_r : cur_x_r;
    base_y = (op == OP_MOVE_ABS) ? org_y_r : cur_y_r;
    sum_x  = XW'(base_x) + XW'(coord_x);
    sum_y  = XW'(base_y) + XW'(coord_y);
    tgt_x  = sat_pos(sum_x);
    tgt_y  = sat_pos(sum_y);
    if (clamp_en) begin
      tgt_x = clamp_axis(tgt_x, lim_x_r);
      tgt_y = clamp_axis(tgt_y, lim_y_r);
    end

    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    org_x_nxt = org_x_r;
    org_y_nxt = org_y_r;
    lim_x_nxt = lim_x_r;
    lim_y_nxt = lim_y_r;
    item_nxt  = item_r;
    if (dn_rdy) begin
      item_nxt.valid = 1'b0;
    end

    if (acc) begin
      unique case (op) inside
        OP_MOVE_REL, OP_MOVE_ABS: begin
          cur_x_nxt = tgt_x;
          cur_y_nxt = tgt_y;
          item_nxt  = '{valid: 1'b1, emit: 1'b1, dur: dur};
        end
        OP_SET_POS: begin
          cur_x_nxt = sat_pos(XW'(coord_x));
          cur_y_nxt = sat_pos(XW'(coord_y));
          item_nxt  = '{valid: 1'b1, emit: 1'b0, dur: dur};
        end
        OP_CAPTURE_LIMIT: begin
          lim_x_nxt = cur_x_r;
          lim_y_nxt = cur_y_r;
        end
        OP_CAPTURE_ORIGIN: begin
          org_x_nxt = cur_x_r;
          org_y_nxt = cur_y_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      org_x_r      <= '0;
      org_y_r      <= '0;
      lim_x_r      <= POS_MAX;
      lim_y_r      <= POS_MAX;
      item_r.valid <= 1'b0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      org_x_r <= org_x_nxt;
      org_y_r <= org_y_nxt;
      lim_x_r <= lim_x_nxt;
      lim_y_r <= lim_y_nxt;
      item_r  <= item_nxt;
    end
  end

  a_capture_limit: assert property (@(posedge clk) disable iff (!rst_n)
    acc && op == OP_CAPTURE_LIMIT |=>
      lim_x_r == $past(cur_x_r) && lim_y_r == $past(cur_y_r))
    else $error("limit not captured from current position");

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (op == OP_MOVE_REL || op == OP_MOVE_ABS) && clamp_en && !lim_x_r[PW-1] |=>
      !cur_x_r[PW-1] && cur_x_r <= $past(lim_x_r))
    else $error("clamped X outside zero to limit");

  a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    acc && op != OP_MOVE_REL && op != OP_MOVE_ABS && op != OP_SET_POS &&
    op != OP_CAPTURE_LIMIT && op != OP_CAPTURE_ORIGIN |=>
      !item_r.valid && $stable(cur_x_r) && $stable(lim_x_r) && $stable(org_x_r))
    else $error("unused op changed state");

endmodule

>>> design/cxmp_scale.sv
// Scale stage: motor coordinates times steps per millimetre, rounded.
module cxmp_scale #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic [cxmp_pkg::SPM_W-1:0]                           spm,
  input  cxmp_pkg::stg_t                                       up_item,
  input  logic signed [POSITION_WIDTH-1:0]                     pos_x,
  input  logic signed [POSITION_WIDTH-1:0]                     pos_y,
  input  logic                                                 dn_rdy,
  output logic                                                 up_rdy,
  output cxmp_pkg::stg_t                                       dn_item,
  output logic [POSITION_WIDTH+cxmp_pkg::SPM_W+1-cxmp_pkg::ROUND_SHIFT:0] q_a,
  output logic [POSITION_WIDTH+cxmp_pkg::SPM_W+1-cxmp_pkg::ROUND_SHIFT:0] q_b,
  output logic                                                 neg_a,
  output logic                                                 neg_b
);
  import cxmp_pkg::*;

  localparam int MW  = POSITION_WIDTH + 1;
  localparam int PRW = MW + SPM_W;
  localparam int QW  = PRW + 1 - ROUND_SHIFT;
  localparam logic [PRW:0] HALF = (PRW + 1)'(1) << (ROUND_SHIFT - 1);

  logic signed [MW-1:0] d_a, d_b;
  logic        [MW-1:0] mag_a, mag_b;
  logic        [PRW-1:0] prod_a, prod_b;
  logic        [PRW:0]   rnd_a, rnd_b;
  logic        [QW-1:0]  q_a_r, q_b_r;
  logic                  neg_a_r, neg_b_r;
  stg_t                  item_r, item_nxt;
  logic                  take;

  assign up_rdy  = !item_r.valid || dn_rdy;
  assign take    = up_item.valid && up_rdy;
  assign dn_item = item_r;
  assign q_a     = q_a_r;
  assign q_b     = q_b_r;
  assign neg_a   = neg_a_r;
  assign neg_b   = neg_b_r;

  always_comb begin
    d_a    = MW'(pos_x) - MW'(pos_y);
    d_b    = MW'(pos_x) + MW'(pos_y);
    mag_a  = d_a[MW-1] ? MW'(-d_a) : MW'(d_a);
    mag_b  = d_b[MW-1] ? MW'(-d_b) : MW'(d_b);
    prod_a = PRW'(mag_a) * PRW'(spm);
    prod_b = PRW'(mag_b) * PRW'(spm);
    rnd_a  = (PRW + 1)'(prod_a) + HALF;
    rnd_b  = (PRW + 1)'(prod_b) + HALF;
    item_nxt = item_r;
    if (take) begin
      item_nxt = up_item;
    end else if (dn_rdy) begin
      item_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_a_r   <= rnd_a[PRW:ROUND_SHIFT];
      q_b_r   <= rnd_b[PRW:ROUND_SHIFT];
      neg_a_r <= d_a[MW-1];
      neg_b_r <= d_b[MW-1];
    end
  end

endmodule

>>> design/cxmp_delta.sv
// Delta stage: motor coordinate saturation, step deltas and result register.
module cxmp_delta #(
  parameter int STEP_WIDTH = 32,
  parameter int Q_WIDTH    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cxmp_pkg::stg_t                   up_item,
  input  logic [Q_WIDTH-1:0]               q_a,
  input  logic [Q_WIDTH-1:0]               q_b,
  input  logic                             neg_a,
  input  logic                             neg_b,
  input  logic                             out_tready,
  output logic                             up_rdy,
  output logic                             out_tvalid,
  output logic signed [STEP_WIDTH-1:0]     delta_a,
  output logic signed [STEP_WIDTH-1:0]     delta_b,
  output logic [cxmp_pkg::DUR_W-1:0]       out_dur
);
  import cxmp_pkg::*;

  localparam int SW = STEP_WIDTH;
  localparam int CW = (Q_WIDTH > SW ? Q_WIDTH : SW) + 1;
  localparam logic [CW-1:0]        STEP_HALF = CW'(1) << (SW - 1);
  localparam logic signed [SW-1:0] STEP_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] STEP_MIN  = {1'b1, {(SW-1){1'b0}}};

  function automatic logic signed [SW-1:0] to_step(input logic [Q_WIDTH-1:0] q,
                                                   input logic neg);
    logic [CW-1:0] qx;
    qx = CW'(q);
    if (neg) begin
      if (qx > STEP_HALF) return STEP_MIN;
      else return SW'(-qx);
    end else begin
      if (qx >= STEP_HALF) return STEP_MAX;
      else return SW'(qx);
    end
  endfunction

  function automatic logic signed [SW-1:0] sat_step(input logic signed [SW:0] v);
    if (v[SW] == v[SW-1]) return v[SW-1:0];
    else if (v[SW]) return STEP_MIN;
    else return STEP_MAX;
  endfunction

  logic signed [SW-1:0]   motor_a_r, motor_b_r, motor_a_nxt, motor_b_nxt;
  logic signed [SW-1:0]   da_r, db_r;
  logic [DUR_W-1:0]       dur_r;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [SW:0]     diff_a, diff_b;
  logic                   take;

  assign up_rdy     = !up_item.emit || !out_valid_r || out_tready;
  assign take       = up_item.valid && up_rdy;
  assign out_tvalid = out_valid_r;
  assign delta_a    = da_r;
  assign delta_b    = db_r;
  assign out_dur    = dur_r;

  always_comb begin
    motor_a_nxt = to_step(q_a, neg_a);
    motor_b_nxt = to_step(q_b, neg_b);
    diff_a      = (SW + 1)'(motor_a_nxt) - (SW + 1)'(motor_a_r);
    diff_b      = (SW + 1)'(motor_b_nxt) - (SW + 1)'(motor_b_r);
    if (take && up_item.emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_a_r   <= '0;
      motor_b_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        motor_a_r <= motor_a_nxt;
        motor_b_r <= motor_b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && up_item.emit) begin
      da_r  <= sat_step(diff_a);
      db_r  <= sat_step(diff_b);
      dur_r <= up_item.dur;
    end
  end

  a_motor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(motor_a_r) && $stable(motor_b_r))
    else $error("motor coordinate moved without an item");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    take && up_item.emit |=> out_valid_r)
    else $error("move item gave no result");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    take && !up_item.emit |=> out_valid_r == ($past(out_valid_r) && !$past(out_tready)))
    else $error("set position item gave a result");

endmodule

>>> design/corexy_move_planner_core.sv
// Top level of the CoreXY move planner: configuration registers and stage chain.
//
//  channel | direction | tdata / data                          | tuser / index
//  in_     | slave     | coord_x, coord_y, move_duration       | op
//  out_    | master    | delta_a, delta_b, out_duration        | -
//  cfg_    | slave     | register value                        | register number
//
// Three register stages: position, scale (one multiply per motor), delta and result.
// One item per cycle sustained while the output is not stalled; stages register it in turn.
// Set position items pass through to update the motor coordinates but give no result.
// Reset (rst_n low, synchronous) clears position, origin and motor coordinates and sets
// the limits to the largest positive position. Output stall back-pressures stage by stage.
module corexy_move_planner_core #(
  parameter int POSITION_WIDTH = 24,
  parameter int STEP_WIDTH     = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [cxmp_pkg::IN_TDATA_W-1:0]       in_tdata,   // coord_x, coord_y, move_duration
  input  logic [cxmp_pkg::OP_W-1:0]             in_tuser,   // op
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((2 * STEP_WIDTH + cxmp_pkg::DUR_W + 7) / 8) * 8 - 1:0]
                                                out_tdata,  // delta_a, delta_b, out_duration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cxmp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cxmp_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import cxmp_pkg::*;

  localparam int OUT_TDATA_W = ((2 * STEP_WIDTH + DUR_W + 7) / 8) * 8;
  localparam int Q_W         = POSITION_WIDTH + SPM_W + 2 - ROUND_SHIFT;

  logic                             clamp_en_r;
  logic [SPM_W-1:0]                 spm_r;
  stg_t                             p_item, m_item;
  logic                             m_rdy, d_rdy;
  logic signed [POSITION_WIDTH-1:0] pos_x, pos_y;
  logic [Q_W-1:0]                   q_a, q_b;
  logic                             neg_a, neg_b;
  logic signed [STEP_WIDTH-1:0]     delta_a, delta_b;
  logic [DUR_W-1:0]                 out_dur;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_en_r <= 1'b0;
      spm_r      <= SPM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CLAMP_ENABLE: clamp_en_r <= cfg_data[0];
        CFG_STEPS_PER_MM: spm_r      <= cfg_data[SPM_W-1:0];
        default: ;
      endcase
    end
  end

  cxmp_pos #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .clamp_en (clamp_en_r),
    .in_valid (in_tvalid),
    .op       (op_t'(in_tuser)),
    .coord_x  ($signed(in_tdata[COORD_W-1:0])),
    .coord_y  ($signed(in_tdata[2*COORD_W-1:COORD_W])),
    .dur      (in_tdata[IN_TDATA_W-1:2*COORD_W]),
    .dn_rdy   (m_rdy),
    .in_rdy   (in_tready),
    .item     (p_item),
    .pos_x    (pos_x),
    .pos_y    (pos_y)
  );

  cxmp_scale #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .spm     (spm_r),
    .up_item (p_item),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .dn_rdy  (d_rdy),
    .up_rdy  (m_rdy),
    .dn_item (m_item),
    .q_a     (q_a),
    .q_b     (q_b),
    .neg_a   (neg_a),
    .neg_b   (neg_b)
  );

  cxmp_delta #(
    .STEP_WIDTH(STEP_WIDTH),
    .Q_WIDTH   (Q_W)
  ) u_delta (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_item    (m_item),
    .q_a        (q_a),
    .q_b        (q_b),
    .neg_a      (neg_a),
    .neg_b      (neg_b),
    .out_tready (out_tready),
    .up_rdy     (d_rdy),
    .out_tvalid (out_tvalid),
    .delta_a    (delta_a),
    .delta_b    (delta_b),
    .out_dur    (out_dur)
  );

  assign out_tdata = OUT_TDATA_W'({out_dur, delta_b, delta_a});

endmodule
